[rtl/core/cac_pkg.sv]
// ----------------------------------------------------------------------------
// cac_pkg
// Shared sizes and types for the crib alignment counter.
// ----------------------------------------------------------------------------
package cac_pkg;

  // crib store depth, also the depth of the cipher window
  localparam int CribMax = 64;
  localparam int LenW    = $clog2(CribMax + 1);
  localparam int LetterW = 8;
  localparam int CountW  = 16;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef logic [LetterW-1:0] letter_t;
  typedef letter_t [CribMax-1:0] letter_arr_t;
  typedef logic [LenW-1:0] len_t;
  typedef logic [CountW-1:0] count_t;

  function automatic count_t sat_inc(count_t v);
    return (v == CountMax) ? v : v + count_t'(1);
  endfunction

endpackage

[rtl/core/cac_match.sv]
// ----------------------------------------------------------------------------
// cac_match
// Parallel compare of the crib against the cipher window for one alignment.
// ----------------------------------------------------------------------------
module cac_match (
  input  cac_pkg::letter_arr_t crib_i,   // newest crib letter at index 0
  input  cac_pkg::letter_arr_t window_i, // newest cipher letter at index 0
  input  cac_pkg::len_t        len_i,
  output logic                 clash_o
);

  logic [cac_pkg::CribMax-1:0] hit;

  always_comb begin
    for (int i = 0; i < cac_pkg::CribMax; i++) begin
      hit[i] = (cac_pkg::len_t'(i) < len_i) && (crib_i[i] == window_i[i]);
    end
  end

  assign clash_o = |hit;

endmodule

[rtl/core/crib_alignment_counter.sv]
// ----------------------------------------------------------------------------
// crib_alignment_counter
// Enigma crib dragging: counts crib alignments with no self-encrypted letter.
// ----------------------------------------------------------------------------
// Beats with func_i = 0 append a crib letter (up to CribMax, extra ones are
// dropped); beats with func_i = 1 shift a cipher letter into the window and
// test the alignment ending on it. A cipher beat with last_i = 1 produces one
// result beat (possible_count_o, or stop_o when the crib is longer than the
// ciphertext) and clears the run; a new crib must be loaded afterwards. The
// block takes one beat per cycle: a beat is held in the input register, the
// full-width window compare and the counter updates act on it there, and a
// result is registered in the output register. Only a result beat waiting
// behind a stalled output register holds off the input; crib and plain cipher
// beats keep flowing.
// ----------------------------------------------------------------------------
module crib_alignment_counter (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   func_i,
  input  cac_pkg::letter_t       letter_i,
  input  logic                   last_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output cac_pkg::count_t        possible_count_o,
  output logic                   stop_o
);

  // input register
  logic             s1_valid_q, s1_valid_d;
  logic             s1_func_q;
  logic             s1_last_q;
  cac_pkg::letter_t s1_letter_q;

  // run state
  cac_pkg::letter_arr_t crib_q, crib_d;     // crib, newest letter first
  cac_pkg::letter_arr_t win_q, win_d;       // cipher window, newest first
  cac_pkg::letter_arr_t win_shift;
  cac_pkg::len_t        len_q, len_d;
  cac_pkg::count_t      seen_q, seen_d;
  cac_pkg::count_t      good_q, good_d;

  // result register
  logic            out_valid_q, out_valid_d;
  cac_pkg::count_t count_q, count_d;
  logic            stop_q, stop_d;

  logic            s1_res, s1_adv, out_free, in_acc, clash;
  cac_pkg::count_t seen_inc, good_upd;

  // --- handshake -----------------------------------------------------------
  assign s1_res   = s1_valid_q & s1_func_q & s1_last_q;
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign s1_adv   = s1_valid_q & (~s1_res | out_free);
  assign in_stall_o = s1_valid_q & ~s1_adv;
  assign in_acc   = in_valid_i & ~in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  // --- alignment test on the window as it stands after this letter ---------
  always_comb begin
    win_shift[0] = s1_letter_q;
    for (int i = 1; i < cac_pkg::CribMax; i++) begin
      win_shift[i] = win_q[i-1];
    end
  end

  cac_match u_match (
    .crib_i   (crib_q),
    .window_i (win_shift),
    .len_i    (len_q),
    .clash_o  (clash)
  );

  assign seen_inc = cac_pkg::sat_inc(seen_q);

  always_comb begin
    good_upd = good_q;
    if (len_q == '0) begin
      good_upd = cac_pkg::sat_inc(good_q);
    end else if ((seen_inc >= cac_pkg::count_t'(len_q)) && !clash) begin
      good_upd = cac_pkg::sat_inc(good_q);
    end
  end

  // --- state update ----------------------------------------------------------
  always_comb begin
    crib_d      = crib_q;
    win_d       = win_q;
    len_d       = len_q;
    seen_d      = seen_q;
    good_d      = good_q;
    out_valid_d = out_valid_q & out_stall_i;
    count_d     = count_q;
    stop_d      = stop_q;
    if (s1_adv) begin
      if (!s1_func_q) begin
        // crib letter: push at the front, drop once the store is full
        if (len_q < cac_pkg::len_t'(cac_pkg::CribMax)) begin
          crib_d[0] = s1_letter_q;
          for (int i = 1; i < cac_pkg::CribMax; i++) begin
            crib_d[i] = crib_q[i-1];
          end
          len_d = len_q + cac_pkg::len_t'(1);
        end
      end else if (s1_last_q) begin
        out_valid_d = 1'b1;
        if (cac_pkg::count_t'(len_q) > seen_inc) begin
          count_d = '0;
          stop_d  = 1'b1;
        end else if (len_q == '0) begin
          count_d = cac_pkg::sat_inc(good_upd);
          stop_d  = 1'b0;
        end else begin
          count_d = good_upd;
          stop_d  = 1'b0;
        end
        // end of run
        len_d  = '0;
        win_d  = '0;
        seen_d = '0;
        good_d = '0;
      end else begin
        win_d  = win_shift;
        seen_d = seen_inc;
        good_d = good_upd;
      end
    end
  end

  // --- registers -------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      len_q       <= '0;
      win_q       <= '0;
      seen_q      <= '0;
      good_q      <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      len_q       <= len_d;
      win_q       <= win_d;
      seen_q      <= seen_d;
      good_q      <= good_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_func_q   <= func_i;
      s1_letter_q <= letter_i;
      s1_last_q   <= last_i;
    end
    crib_q  <= crib_d;
    count_q <= count_d;
    stop_q  <= stop_d;
  end

  assign out_valid_o      = out_valid_q;
  assign possible_count_o = count_q;
  assign stop_o           = stop_q;

  // --- assertions ------------------------------------------------------------
  a_stop_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stop_o |-> possible_count_o == '0)
    else $error("stop result with nonzero count");

  a_clear_after_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_res |=> len_q == '0 && seen_q == '0 && good_q == '0)
    else $error("run state not cleared after result");

  a_good_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    good_q <= seen_q)
    else $error("more possible alignments than cipher letters");

  a_stall_only_on_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_res && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked result");

endmodule
